### src/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 stream converter.
// Holds status codes, decoder state and result types; no dependencies.
package u8u16_pkg;

  // Status codes carried with each result item
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_STRAY   = 3'd1,
    ST_BADCONT = 3'd2,
    ST_INVLEAD = 3'd3,
    ST_TRUNC   = 3'd4
  } status_e;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned OutDepth  = 4;
  localparam int unsigned OutPtrW   = $clog2(OutDepth);
  localparam int unsigned OutCntW   = $clog2(OutDepth + 1);

  localparam logic [CpWidth-1:0] SuppBase  = 21'h10000;
  localparam logic [15:0]        HiSurBase = 16'hD800;
  localparam logic [5:0]         LoSurTag  = 6'b110111;

  // Character assembly state
  typedef struct packed {
    logic [1:0]         bytes_remaining;
    logic [1:0]         char_length;
    logic [CpWidth-1:0] partial_code_point;
    logic               bad_continuation_seen;
    logic               error_discard;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    status_e     status;
    logic        run_end;
  } result_t;

endpackage

### src/u8u16_if.sv
// Stream interfaces for the UTF-8 to UTF-16 converter.
// Depends on u8u16_pkg for the status type.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8u16_out_if
  import u8u16_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  status_e     status;
  logic        run_end;

  modport source (output valid, output code_unit, output status, output run_end,
                  input ready);
  modport sink   (input valid, input code_unit, input status, input run_end,
                  output ready);
endinterface

### src/u8u16_decode.sv
// Single-step UTF-8 decoder: next state and up to two result items per byte.
// Depends on u8u16_pkg.
module u8u16_decode
  import u8u16_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output dec_state_t  state_o,
  output logic [1:0]  num_results_o,
  output result_t     result0_o,
  output result_t     result1_o
);

  logic [CpWidth-1:0] cp_next;
  logic [CpWidth-1:0] supp_off;
  logic [1:0]         rem_next;
  logic               bad_next;

  always_comb begin
    // Continuation arithmetic
    cp_next  = {state_i.partial_code_point[CpWidth-7:0], data_byte_i[5:0]};
    rem_next = state_i.bytes_remaining - 2'd1;
    bad_next = state_i.bad_continuation_seen | (data_byte_i[7:6] != 2'b10);
    supp_off = cp_next - SuppBase;

    state_o       = state_i;
    num_results_o = 2'd0;
    result0_o     = '{code_unit: 16'h0000, status: ST_OK, run_end: 1'b1};
    result1_o     = '{code_unit: 16'h0000, status: ST_OK, run_end: 1'b1};

    if (state_i.error_discard) begin
      // Drop bytes until the end of the string
      if (end_of_string_i) begin
        state_o = '0;
      end
    end else if (state_i.bytes_remaining == 2'd0) begin
      // Lead byte
      state_o.bad_continuation_seen = 1'b0;
      if (!data_byte_i[7]) begin
        num_results_o       = 2'd1;
        result0_o.code_unit = {8'h00, data_byte_i};
      end else if (!data_byte_i[6]) begin
        num_results_o    = 2'd1;
        result0_o.status = ST_STRAY;
        state_o          = '0;
        state_o.error_discard = !end_of_string_i;
      end else if (data_byte_i[3] && data_byte_i[4] && data_byte_i[5]) begin
        num_results_o    = 2'd1;
        result0_o.status = ST_INVLEAD;
        state_o          = '0;
        state_o.error_discard = !end_of_string_i;
      end else if (end_of_string_i) begin
        num_results_o    = 2'd1;
        result0_o.status = ST_TRUNC;
        state_o          = '0;
      end else if (!data_byte_i[5]) begin
        state_o.partial_code_point = {16'h0000, data_byte_i[4:0]};
        state_o.bytes_remaining    = 2'd1;
        state_o.char_length        = 2'd2;
      end else if (!data_byte_i[4]) begin
        state_o.partial_code_point = {17'h00000, data_byte_i[3:0]};
        state_o.bytes_remaining    = 2'd2;
        state_o.char_length        = 2'd3;
      end else begin
        state_o.partial_code_point = {18'h00000, data_byte_i[2:0]};
        state_o.bytes_remaining    = 2'd3;
        state_o.char_length        = 2'd0;
      end
    end else begin
      // Continuation byte
      state_o.partial_code_point    = cp_next;
      state_o.bytes_remaining       = rem_next;
      state_o.bad_continuation_seen = bad_next;
      if (rem_next != 2'd0) begin
        if (end_of_string_i) begin
          num_results_o    = 2'd1;
          result0_o.status = ST_TRUNC;
          state_o          = '0;
        end
      end else if (bad_next) begin
        num_results_o    = 2'd1;
        result0_o.status = ST_BADCONT;
        state_o          = '0;
        state_o.error_discard = !end_of_string_i;
      end else begin
        state_o = '0;
        if ((state_i.char_length == 2'd0) && (cp_next >= SuppBase)) begin
          // Surrogate pair, high unit first
          num_results_o       = 2'd2;
          result0_o.code_unit = HiSurBase | {5'b00000, supp_off[20:10]};
          result0_o.run_end   = 1'b0;
          result1_o.code_unit = {LoSurTag, supp_off[9:0]};
        end else begin
          num_results_o       = 2'd1;
          result0_o.code_unit = cp_next[15:0];
        end
      end
    end
  end

endmodule

### src/utf8_to_utf16_stream_converter.sv
// Top level of the UTF-8 to UTF-16 stream converter.
// Depends on u8u16_pkg, u8u16_if and u8u16_decode.
//
//  channel  dir  payload                            handshake
//  in_i     in   data_byte, end_of_string           valid/ready
//  out_o    out  code_unit, status, run_end          valid/ready
//
// One byte is taken per cycle while the input register is free or advancing; it
// is held in the input register and decoded combinationally into a four-entry
// result queue, from whose head the output is driven. A surrogate pair occupies
// two queue entries, high unit first.
// Reset clears the decoder state and empties both stages. The input register
// holds while the result queue has fewer than two free entries.
module utf8_to_utf16_stream_converter
  import u8u16_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  u8u16_in_if.sink           in_i,
  u8u16_out_if.source        out_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;

  dec_state_t state_q, state_d;
  logic [1:0] num_res;
  result_t    res0, res1;

  result_t             queue_q [OutDepth];
  logic [OutPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]  count_q;
  logic                advance;
  logic                pop;
  logic [OutCntW-1:0]  push_n;
  logic [OutPtrW-1:0]  wr_ptr_p1;

  assign advance     = in_valid_q && (count_q <= OutCntW'(OutDepth - 2));
  assign in_i.ready  = !in_valid_q || advance;
  assign pop         = out_o.valid && out_o.ready;
  assign push_n      = advance ? OutCntW'(num_res) : '0;
  assign wr_ptr_p1   = wr_ptr_q + OutPtrW'(1);

  u8u16_decode u_decode (
    .state_i         (state_q),
    .data_byte_i     (in_byte_q),
    .end_of_string_i (in_eos_q),
    .state_o         (state_d),
    .num_results_o   (num_res),
    .result0_o       (res0),
    .result1_o       (res1)
  );

  // Capture the next item when the register is free or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_eos_q  <= in_i.end_of_string;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutPtrW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      count_q <= count_q + push_n - OutCntW'(pop);
    end
  end

  // Write results into the queue
  always_ff @(posedge clk_i) begin
    if (push_n != '0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_n == OutCntW'(2)) begin
      queue_q[wr_ptr_p1] <= res1;
    end
  end

  // Drive the output from the queue head
  assign out_o.valid     = (count_q != '0);
  assign out_o.code_unit = queue_q[rd_ptr_q].code_unit;
  assign out_o.status    = queue_q[rd_ptr_q].status;
  assign out_o.run_end   = queue_q[rd_ptr_q].run_end;

endmodule
